// File: rtl/cswv_pkg.sv
// Shared types, codes and constants for the charger status block.
package cswv_pkg;

  // Field widths
  localparam int unsigned SwW     = 3;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned SampleW = 12;
  localparam int unsigned LvlW    = 3;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 12;

  localparam int unsigned NumLevels = 5;

  // Default window depths
  localparam int unsigned CswvVoteDepth = 3;
  localparam int unsigned CswvAvgDepth  = 10;

  // Reset fan thresholds
  localparam logic [SampleW-1:0] FanOnRst  = SampleW'(30);
  localparam logic [SampleW-1:0] FanOffRst = SampleW'(15);

  // Switch state codes; anything above SwOff leaves the status alone
  localparam logic [SwW-1:0] SwBothOn   = 3'd0;
  localparam logic [SwW-1:0] SwFirstOn  = 3'd1;
  localparam logic [SwW-1:0] SwSecondOn = 3'd2;
  localparam logic [SwW-1:0] SwOff      = 3'd3;

  localparam logic [LvlW-1:0] LvlNone = 3'd0;
  localparam logic [LvlW-1:0] LvlFull = 3'd5;

  typedef enum logic [1:0] {
    StWaiting  = 2'd0,
    StCharging = 2'd1,
    StFull     = 2'd2,
    StError    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CauseNone    = 2'd0,
    CauseTimeout = 2'd1,
    CauseSwitch  = 2'd2
  } cause_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLevel1  = 3'd0,
    CfgLevel2  = 3'd1,
    CfgLevel3  = 3'd2,
    CfgLevel4  = 3'd3,
    CfgFull    = 3'd4,
    CfgFanOn   = 3'd5,
    CfgFanOff  = 3'd6
  } cfg_idx_e;

  typedef logic [NumLevels-1:0][CodeW-1:0] level_codes_t;

  typedef struct packed {
    status_e         status;
    logic [LvlW-1:0] level;
    cause_e          cause;
  } charge_t;

endpackage

// File: rtl/cswv_status.sv
// ID classification, majority vote window and charge status state.
module cswv_status import cswv_pkg::*; #(
  parameter int unsigned VoteDepth = CswvVoteDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [SwW-1:0]   sw_i,
  input  logic [CodeW-1:0] id_i,
  input  level_codes_t     codes_i,
  output charge_t          chg_o
);

  localparam int unsigned CntW = $clog2(VoteDepth + 1);

  logic [VoteDepth-1:0][LvlW-1:0] win_q, win_d, win_shift;
  charge_t                        chg_q, chg_d;
  logic [LvlW-1:0]                cls;
  logic [NumLevels-1:0][CntW-1:0] cnt;
  logic [CntW-1:0]                best;
  logic [LvlW-1:0]                winner;

  // Lowest matching level wins when codes are duplicated
  always_comb begin
    cls = LvlNone;
    if (id_i != '0) begin
      for (int l = NumLevels - 1; l >= 0; l--) begin
        if (id_i == codes_i[l]) cls = LvlW'(l + 1);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VoteDepth - 1; i++) win_shift[i] = win_q[i+1];
    win_shift[VoteDepth-1] = cls;
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < VoteDepth; i++) begin
      for (int l = 0; l < NumLevels; l++) begin
        if (win_shift[i] == LvlW'(l + 1)) cnt[l] = cnt[l] + CntW'(1);
      end
    end
  end

  // First strictly greatest count; empty vote falls back to level one
  always_comb begin
    best   = '0;
    winner = LvlW'(1);
    for (int l = 0; l < NumLevels; l++) begin
      if (cnt[l] > best) begin
        best   = cnt[l];
        winner = LvlW'(l + 1);
      end
    end
  end

  always_comb begin
    chg_d = chg_q;
    win_d = win_q;
    case (sw_i) inside
      SwBothOn: begin
        if (id_i != '0) begin
          win_d        = win_shift;
          chg_d.level  = winner;
          chg_d.status = (winner == LvlFull) ? StFull : StCharging;
        end else if (chg_q.status != StFull && chg_q.status != StCharging) begin
          chg_d.level  = LvlNone;
          chg_d.status = StError;
          chg_d.cause  = CauseTimeout;
        end
      end
      SwFirstOn, SwSecondOn: begin
        chg_d.level  = LvlNone;
        chg_d.status = StError;
        chg_d.cause  = CauseSwitch;
        win_d        = '0;
      end
      SwOff: begin
        chg_d.level  = LvlNone;
        chg_d.status = StWaiting;
        win_d        = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      chg_q.status <= StWaiting;
      chg_q.level  <= LvlNone;
      chg_q.cause  <= CauseNone;
    end else if (upd_i) begin
      win_q <= win_d;
      chg_q <= chg_d;
    end
  end

  assign chg_o = chg_q;

endmodule

// File: rtl/cswv_avg.sv
// Temperature sample ring, running sum and divide by the ring depth.
module cswv_avg import cswv_pkg::*; #(
  parameter int unsigned AvgDepth = CswvAvgDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [SampleW-1:0] avg_o
);

  localparam int unsigned PosW     = (AvgDepth > 1) ? $clog2(AvgDepth) : 1;
  // Reciprocal is exact for every 16-bit sum at depths up to 16
  localparam int unsigned DivShift = 21;
  localparam int unsigned RecipW   = DivShift + 1;
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam longint unsigned RecipVal =
    ((64'd1 << DivShift) + AvgDepth - 1) / AvgDepth;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipVal);

  logic [AvgDepth-1:0][SampleW-1:0] ring_q;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic [SumW-1:0]                  sum_q, sum_d;
  logic [ProdW-1:0]                 prod;

  assign sum_d = sum_q - SumW'(ring_q[pos_q]) + SumW'(sample_i);
  assign pos_d = (pos_q == PosW'(AvgDepth - 1)) ? '0 : pos_q + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q <= '0;
      pos_q  <= '0;
      sum_q  <= '0;
    end else if (upd_i) begin
      ring_q[pos_q] <= sample_i;
      pos_q         <= pos_d;
      sum_q         <= sum_d;
    end
  end

  assign prod  = ProdW'(sum_q) * ProdW'(Recip);
  assign avg_o = prod[DivShift +: SampleW];

endmodule

// File: rtl/charger_status_with_id_vote_and_fan.sv
// Top level: config registers, three-stage tick pipeline and fan hysteresis.
//
// One poll tick per transfer, one result per tick, and a new tick can be taken
// every clock cycle while the output is not stalled. A tick passes through
// the input register, then the stage where the vote window, status and running
// sample sum are updated, then the result register where the average (sum times
// a fixed reciprocal) and the fan hysteresis are settled. The running sum and
// the status registers are updated once per tick, which sets the rate at one
// tick per cycle without back-pressure. Configuration writes are always taken
// and must only be made while no tick is in flight.
module charger_status_with_id_vote_and_fan import cswv_pkg::*; #(
  parameter int unsigned VoteDepth = CswvVoteDepth,
  parameter int unsigned AvgDepth  = CswvAvgDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SwW-1:0]     switch_state_i,
  input  logic [CodeW-1:0]   remote_id_i,
  input  logic [SampleW-1:0] temp_sample_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [LvlW-1:0]    power_level_o,
  output logic [1:0]         error_cause_o,
  output logic               fan_on_o,
  output logic [SampleW-1:0] sample_average_o
);

  level_codes_t       codes_q;
  logic [SampleW-1:0] fan_on_q, fan_off_q;

  logic               s1_vld_q, s2_vld_q, out_vld_q;
  logic [SwW-1:0]     sw_q;
  logic [CodeW-1:0]   id_q;
  logic [SampleW-1:0] smp_q;

  logic               out_adv, s1_adv, in_xfer;
  charge_t            chg, chg_out_q;
  logic [SampleW-1:0] avg, avg_out_q;
  logic               fan_q, fan_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NumLevels; l++) codes_q[l] <= CodeW'(l + 1);
      fan_on_q  <= FanOnRst;
      fan_off_q <= FanOffRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLevel1: codes_q[0] <= cfg_data_i[CodeW-1:0];
        CfgLevel2: codes_q[1] <= cfg_data_i[CodeW-1:0];
        CfgLevel3: codes_q[2] <= cfg_data_i[CodeW-1:0];
        CfgLevel4: codes_q[3] <= cfg_data_i[CodeW-1:0];
        CfgFull:   codes_q[4] <= cfg_data_i[CodeW-1:0];
        CfgFanOn:  fan_on_q   <= cfg_data_i[SampleW-1:0];
        CfgFanOff: fan_off_q  <= cfg_data_i[SampleW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow: each stage moves when the one after it is free or moving
  assign out_adv    = s2_vld_q && (!out_vld_q || out_ready_i);
  assign s1_adv     = s1_vld_q && (!s2_vld_q || out_adv);
  assign in_ready_o = !s1_vld_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_vld_q <= in_valid_i;
      if (!s2_vld_q || out_adv) s2_vld_q <= s1_adv;
      if (!out_vld_q || out_ready_i) out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sw_q  <= switch_state_i;
      id_q  <= remote_id_i;
      smp_q <= temp_sample_i;
    end
  end

  // State registers in these units double as the second stage payload
  cswv_status #(
    .VoteDepth(VoteDepth)
  ) u_status (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (s1_adv),
    .sw_i    (sw_q),
    .id_i    (id_q),
    .codes_i (codes_q),
    .chg_o   (chg)
  );

  cswv_avg #(
    .AvgDepth(AvgDepth)
  ) u_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (s1_adv),
    .sample_i (smp_q),
    .avg_o    (avg)
  );

  // Off test applied last so it wins when both thresholds hold
  always_comb begin
    fan_d = fan_q;
    if (avg > fan_on_q)  fan_d = 1'b1;
    if (avg < fan_off_q) fan_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q <= 1'b0;
    end else if (out_adv) begin
      fan_q <= fan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      chg_out_q <= chg;
      avg_out_q <= avg;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = chg_out_q.status;
  assign power_level_o    = chg_out_q.level;
  assign error_cause_o    = chg_out_q.cause;
  assign fan_on_o         = fan_q;
  assign sample_average_o = avg_out_q;

endmodule
